FILE: rtl/htl_pkg.sv
package htl_pkg;

  localparam int FL_W          = 17;
  localparam int NAME_LIMIT_W  = 11;
  localparam int VALUE_LIMIT_W = 16;
  localparam int CFG_W         = 16;
  localparam int RUN_MAX       = 3;
  localparam int FQ_DEPTH      = 4;
  localparam int FQ_PTR_W      = 2;
  localparam int FQ_CNT_W      = 3;

  localparam logic [2:0] KIND_NAME        = 3'd0;
  localparam logic [2:0] KIND_VALUE       = 3'd1;
  localparam logic [2:0] KIND_FIELD_END   = 3'd2;
  localparam logic [2:0] KIND_HEADERS_END = 3'd3;
  localparam logic [2:0] KIND_ERROR       = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NAME_LONG = 3'd1;
  localparam logic [2:0] ERR_VALUE_LONG = 3'd2;
  localparam logic [2:0] ERR_NO_COLON  = 3'd3;
  localparam logic [2:0] ERR_NO_EMPTY  = 3'd4;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic CFG_NAME_LIMIT  = 1'b0;
  localparam logic CFG_VALUE_LIMIT = 1'b1;

  localparam logic [NAME_LIMIT_W-1:0]  NAME_LIMIT_RST  = 11'd256;
  localparam logic [VALUE_LIMIT_W-1:0] VALUE_LIMIT_RST = 16'd8192;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_message;
    logic       end_of_chunk;
  } in_word_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;
  } res_t;

  // all results of one input byte
  typedef struct packed {
    res_t [RUN_MAX-1:0] res;
    logic [1:0]         cnt;
  } run_t;

  typedef struct packed {
    logic                full;
    logic                empty;
    logic [FQ_CNT_W-1:0] count;
  } q_stat_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] b, logic [2:0] err);
    res_t r;
    r.kind       = kind;
    r.out_byte   = b;
    r.error_code = err;
    return r;
  endfunction

endpackage

FILE: rtl/http_header_line_tokenizer.sv
// Words of an accepted byte are registered into the run queue and leave its head.
// Throughput: one input byte per cycle while each byte yields at most one word and
// out_ready is high; the output drains one word per cycle while out_ready is high,
// and bytes yielding 2 or 3 words are buffered in a 4-entry run queue before input stalls.
// Reset (synchronous, rst_n low): parser state and queue clear, limits 256/8192.
module http_header_line_tokenizer import htl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word
);

  q_stat_t q_stat;
  run_t    q_run;
  run_t    q_head;
  logic    q_push;
  logic    q_pop;

  htl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_run     (q_run)
  );

  htl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_run (q_run),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  htl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= FQ_CNT_W'(FQ_DEPTH))
    else $error("run queue count beyond depth");

  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_word.last_of_run) |=> out_valid)
    else $error("run broken before its last word");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_word.kind == KIND_ERROR) == (out_word.error_code != ERR_NONE)))
    else $error("error code does not match kind");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.kind != KIND_NAME && out_word.kind != KIND_VALUE)
      |-> (out_word.out_byte == CH_NUL))
    else $error("marker word carries a byte");
`endif

endmodule

FILE: rtl/htl_front.sv
module htl_front import htl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  input  q_stat_t          q_stat,
  output logic             q_push,
  output run_t             q_run
);

  logic [NAME_LIMIT_W-1:0]  name_limit_r;
  logic [VALUE_LIMIT_W-1:0] value_limit_r;
  logic                     in_value_r, in_value_nxt;
  logic [FL_W-1:0]          field_length_r, field_length_nxt;
  logic                     cr_held_r, cr_held_nxt;
  logic                     finished_r, finished_nxt;
  logic                     accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic            iv;
    logic [FL_W-1:0] fl;
    logic            cr;
    logic            fin;
    logic            first;
    logic [2:0]      kind;
    logic [FL_W-1:0] limit;
    logic [1:0]      n;
    logic [7:0]      b;
    iv    = in_value_r;
    fl    = field_length_r;
    cr    = cr_held_r;
    fin   = finished_r;
    b     = in_word.data_byte;
    first = 1'b0;
    n     = 2'd0;
    q_run = '0;
    if (in_word.new_message) begin
      iv  = 1'b0;
      fl  = '0;
      cr  = 1'b0;
      fin = 1'b0;
    end
    kind  = iv ? KIND_VALUE : KIND_NAME;
    limit = iv ? {{(FL_W-VALUE_LIMIT_W){1'b0}}, value_limit_r}
               : {{(FL_W-NAME_LIMIT_W){1'b0}}, name_limit_r};
    if (!fin) begin
      if (fl >= limit) begin
        q_run.res[n] = mk_res(KIND_ERROR, CH_NUL, iv ? ERR_VALUE_LONG : ERR_NAME_LONG);
        n   = n + 2'd1;
        cr  = 1'b0;
        fin = 1'b1;
      end else if (b == CH_LF) begin
        if (iv) begin
          q_run.res[n] = mk_res(KIND_FIELD_END, CH_NUL, ERR_NONE);
          n  = n + 2'd1;
          cr = 1'b0;
          iv = 1'b0;
          fl = '0;
        end else if (fl == '0 || (fl == {{(FL_W-1){1'b0}}, 1'b1} && cr)) begin
          q_run.res[n] = mk_res(KIND_HEADERS_END, CH_NUL, ERR_NONE);
          n   = n + 2'd1;
          cr  = 1'b0;
          fin = 1'b1;
        end else begin
          q_run.res[n] = mk_res(KIND_ERROR, CH_NUL, ERR_NO_COLON);
          n   = n + 2'd1;
          cr  = 1'b0;
          fin = 1'b1;
        end
      end else begin
        // held CR turns out to be data
        if (cr) begin
          q_run.res[n] = mk_res(kind, CH_CR, ERR_NONE);
          n  = n + 2'd1;
          cr = 1'b0;
        end
        if (!iv && b == CH_COLON) begin
          iv = 1'b1;
          fl = '0;
        end else begin
          first = (fl == '0);
          fl    = fl + {{(FL_W-1){1'b0}}, 1'b1};
          if (b == CH_CR) begin
            cr = 1'b1;
          end else if (!(iv && first && b == CH_SPACE)) begin
            q_run.res[n] = mk_res(kind, b, ERR_NONE);
            n = n + 2'd1;
          end
        end
      end
      if (!fin && in_word.end_of_chunk) begin
        q_run.res[n] = mk_res(KIND_ERROR, CH_NUL, ERR_NO_EMPTY);
        n   = n + 2'd1;
        cr  = 1'b0;
        fin = 1'b1;
      end
    end
    q_run.cnt        = n;
    in_value_nxt     = iv;
    field_length_nxt = fl;
    cr_held_nxt      = cr;
    finished_nxt     = fin;
  end

  assign q_push = accept && (q_run.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_limit_r   <= NAME_LIMIT_RST;
      value_limit_r  <= VALUE_LIMIT_RST;
      in_value_r     <= 1'b0;
      field_length_r <= '0;
      cr_held_r      <= 1'b0;
      finished_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NAME_LIMIT:  name_limit_r  <= cfg_wdata[NAME_LIMIT_W-1:0];
          CFG_VALUE_LIMIT: value_limit_r <= cfg_wdata[VALUE_LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        in_value_r     <= in_value_nxt;
        field_length_r <= field_length_nxt;
        cr_held_r      <= cr_held_nxt;
        finished_r     <= finished_nxt;
      end
    end
  end

endmodule

FILE: rtl/htl_queue.sv
module htl_queue import htl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  run_t    push_run,
  input  logic    pop,
  output run_t    head,
  output q_stat_t stat
);

  run_t                entry_r [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FQ_CNT_W-1:0] count_r;
  logic                do_push, do_pop;

  assign stat.full  = (count_r == FQ_CNT_W'(FQ_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + FQ_PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + FQ_PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + FQ_CNT_W'(1);
        2'b01:   count_r <= count_r - FQ_CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/htl_back.sv
module htl_back import htl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  run_t      q_head,
  input  q_stat_t   q_stat,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic [1:0] idx_r;
  res_t       cur;
  logic       last;

  assign cur       = q_head.res[idx_r];
  assign last      = (idx_r == q_head.cnt - 2'd1);
  assign out_valid = !q_stat.empty;

  assign out_word.kind        = cur.kind;
  assign out_word.out_byte    = cur.out_byte;
  assign out_word.error_code  = cur.error_code;
  assign out_word.last_of_run = last;

  assign q_pop = out_valid && out_ready && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (out_valid && out_ready) begin
      idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule

FILE: test/header_token_checker.sv
`timescale 1ns / 1ps

module header_token_checker import htl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_word_t         in_word,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_word_t        out_word,
  output int               tokens_owed,
  output int               mismatches
);

  localparam logic [2:0] K_NAME = KIND_NAME[2:0];

  // shadow of the parser
  logic                     in_val;
  logic                     cr_pend;
  logic                     done;
  logic [FL_W-1:0]          flen;
  logic [NAME_LIMIT_W-1:0]  name_lim;
  logic [VALUE_LIMIT_W-1:0] value_lim;

  out_word_t run_buf [RUN_MAX];
  int        run_len;
  out_word_t pending_tokens [$];

  initial begin
    tokens_owed = 0;
    mismatches  = 0;
  end

  function automatic void note(logic [2:0] k, logic [7:0] b, logic [2:0] e);
    run_buf[run_len].kind        = k;
    run_buf[run_len].out_byte    = b;
    run_buf[run_len].error_code  = e;
    run_buf[run_len].last_of_run = 1'b0;
    run_len++;
  endfunction

  // an error drops any held CR and stops parsing
  function automatic void stop_with(logic [2:0] e);
    cr_pend = 1'b0;
    done    = 1'b1;
    note(KIND_ERROR, CH_NUL, e);
  endfunction

  task automatic tokenize_byte(in_word_t w);
    logic [2:0]      k;
    logic [FL_W-1:0] lim;
    logic            first;
    run_len = 0;
    if (w.new_message) begin
      in_val  = 1'b0;
      flen    = '0;
      cr_pend = 1'b0;
      done    = 1'b0;
    end
    if (!done) begin
      k   = in_val ? KIND_VALUE : K_NAME;
      lim = in_val ? FL_W'(value_lim) : FL_W'(name_lim);
      if (flen >= lim) begin
        stop_with(in_val ? ERR_VALUE_LONG : ERR_NAME_LONG);
      end else if (w.data_byte == CH_LF) begin
        if (in_val) begin
          cr_pend = 1'b0;
          note(KIND_FIELD_END, CH_NUL, ERR_NONE);
          in_val = 1'b0;
          flen   = '0;
        end else if (flen == 0 || (flen == 1 && cr_pend)) begin
          cr_pend = 1'b0;
          done    = 1'b1;
          note(KIND_HEADERS_END, CH_NUL, ERR_NONE);
        end else begin
          stop_with(ERR_NO_COLON);
        end
      end else begin
        if (cr_pend) begin
          note(k, CH_CR, ERR_NONE);
          cr_pend = 1'b0;
        end
        if (!in_val && w.data_byte == CH_COLON) begin
          in_val = 1'b1;
          flen   = '0;
        end else begin
          first = (flen == 0);
          flen  = flen + 1'b1;
          if (w.data_byte == CH_CR)
            cr_pend = 1'b1;
          else if (!(in_val && first && w.data_byte == CH_SPACE))
            note(k, w.data_byte, ERR_NONE);
        end
      end
      if (!done && w.end_of_chunk)
        stop_with(ERR_NO_EMPTY);
    end
    if (run_len > 0)
      run_buf[run_len-1].last_of_run = 1'b1;
    for (int i = 0; i < run_len; i++)
      pending_tokens = {pending_tokens, run_buf[i]};
  endtask

  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      name_lim  = NAME_LIMIT_RST;
      value_lim = VALUE_LIMIT_RST;
      in_val    = 1'b0;
      cr_pend   = 1'b0;
      done      = 1'b0;
      flen      = '0;
      pending_tokens.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NAME_LIMIT)
          name_lim = cfg_wdata[NAME_LIMIT_W-1:0];
        else
          value_lim = cfg_wdata[VALUE_LIMIT_W-1:0];
      end
      if (in_valid && in_ready)
        tokenize_byte(in_word);
      if (out_valid && out_ready) begin
        if (pending_tokens.size() == 0) begin
          if (mismatches < 10)
            $display("%0t unexpected word: kind %0d byte %02h err %0d last %0b", $realtime,
                     out_word.kind, out_word.out_byte, out_word.error_code,
                     out_word.last_of_run);
          mismatches++;
        end else begin
          want = pending_tokens.pop_front();
          if (want.kind !== out_word.kind || want.out_byte !== out_word.out_byte ||
              want.error_code !== out_word.error_code ||
              want.last_of_run !== out_word.last_of_run) begin
            if (mismatches < 10)
              $display("%0t mismatch: exp kind %0d byte %02h err %0d last %0b,",
                       $realtime, want.kind, want.out_byte, want.error_code,
                       want.last_of_run,
                       " got kind %0d byte %02h err %0d last %0b",
                       out_word.kind, out_word.out_byte,
                       out_word.error_code, out_word.last_of_run);
            mismatches++;
          end
        end
      end
    end
    tokens_owed = pending_tokens.size();
  end

endmodule

FILE: test/http_header_line_tokenizer_tb.sv
`timescale 1ns / 1ps

module http_header_line_tokenizer_tb import htl_pkg::*;;

  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_ITEMS = 50;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  in_word_t         in_word;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_word;

  int tokens_owed;
  int mismatches;
  int idle_cycles = 0;

  in_word_t msg_q [$];
  bit       fresh;
  bit       steady;
  int       phase_count;

  http_header_line_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  header_token_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .tokens_owed (tokens_owed),
    .mismatches  (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 1;
    if (r < 90) return $urandom_range(2, 4);
    if (r < 97) return $urandom_range(5, 12);
    return $urandom_range(20, 50);
  endfunction

  // receiver: random stalls with occasional calm stretches
  int ready_hold = 0;
  int calm_left  = 0;
  int ready_roll;
  always @(negedge clk) begin
    if (calm_left > 0) begin
      calm_left--;
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 2) begin
        calm_left = $urandom_range(30, 80);
        out_ready <= 1'b1;
      end else if (ready_roll < 70) begin
        out_ready <= 1'b1;
      end else begin
        ready_hold = pick_gap() - 1;
        out_ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_word(in_word_t w);
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // stop sending until every expected word is out, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tokens_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic add_byte(logic [7:0] b, bit eoc = 1'b0);
    in_word_t w;
    w.data_byte    = b;
    w.new_message  = fresh;
    w.end_of_chunk = eoc;
    fresh = 1'b0;
    msg_q = {msg_q, w};
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++)
      add_byte(s[i]);
  endtask

  task automatic send_msg();
    foreach (msg_q[i]) begin
      send_word(msg_q[i]);
      if (!steady && $urandom_range(0, 99) < 25)
        hold_off(pick_gap());
    end
    msg_q.delete();
  endtask

  function automatic logic [7:0] text_byte(bit colon_ok);
    logic [7:0] b;
    if ($urandom_range(0, 99) < 6) return CH_CR;
    b = 8'($urandom_range(0, 255));
    if (b == CH_LF || (!colon_ok && b == CH_COLON))
      b = 8'h41 + 8'($urandom_range(0, 25));
    return b;
  endfunction

  function automatic int pick_len(int lim);
    int hi;
    if ($urandom_range(0, 99) < 80) return $urandom_range(0, 6);
    hi = (lim + 1 > 40) ? 40 : lim + 1;
    return $urandom_range(0, hi);
  endfunction

  task automatic add_eol();
    if ($urandom_range(0, 99) < 70)
      add_byte(CH_CR);
    add_byte(CH_LF);
  endtask

  task automatic gen_line(int nl, int vl);
    int t;
    int n;
    t = $urandom_range(0, 99);
    if (t < 78) begin
      n = pick_len(nl);
      repeat (n) add_byte(text_byte(1'b0));
      add_byte(CH_COLON);
      case ($urandom_range(0, 3))
        0, 1: add_byte(CH_SPACE);
        2: begin
          add_byte(CH_SPACE);
          add_byte(CH_SPACE);
        end
        default: ;
      endcase
      n = pick_len(vl);
      repeat (n) add_byte(text_byte(1'b1));
      add_eol();
    end else if (t < 90) begin
      n = pick_len(nl);
      repeat (n) add_byte(text_byte(1'b0));
      add_eol();
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
      add_byte(CH_LF);
    end
  endtask

  task automatic gen_message(int nl, int vl);
    in_word_t w;
    int       k;
    int       n;
    steady = ($urandom_range(0, 99) < 15);
    if ($urandom_range(0, 99) < 10) begin
      // raw noise, flags included
      n = $urandom_range(1, 8);
      repeat (n) begin
        fresh = 1'($urandom_range(0, 1));
        add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      phase_count += msg_q.size();
    end else begin
      fresh = 1'b1;
      n = $urandom_range(0, 4);
      repeat (n) gen_line(nl, vl);
      k = $urandom_range(0, 99);
      if (k < 60) begin
        add_byte(CH_CR);
        add_byte(CH_LF);
      end else if (k < 85) begin
        add_byte(CH_LF);
      end
      if (msg_q.size() == 0)
        add_byte(CH_LF);
      k = $urandom_range(0, 99);
      if (k < 93) begin
        // mostly on the last byte, sometimes cut short
        k = (k < 85) ? msg_q.size() - 1 : $urandom_range(0, msg_q.size() - 1);
        w = msg_q[k];
        w.end_of_chunk = 1'b1;
        msg_q[k] = w;
      end
      phase_count += msg_q.size();
      if ($urandom_range(0, 99) < 20) begin
        n = $urandom_range(1, 3);
        repeat (n) add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    send_msg();
  endtask

  task automatic run_phase(int nl, int vl);
    write_reg(CFG_NAME_LIMIT, CFG_W'(nl));
    write_reg(CFG_VALUE_LIMIT, CFG_W'(vl));
    phase_count = 0;
    while (phase_count < PHASE_ITEMS) begin
      gen_message(nl, vl);
      if ($urandom_range(0, 99) < 5)
        settle();
    end
    settle();
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_NAME_LIMIT;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_word   = '0;
    fresh     = 1'b0;
    steady    = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset limits: leading space, held CR, byte extremes, empty name, header end
    fresh = 1'b1;
    add_text("A: b");
    add_byte(CH_CR);
    add_byte(CH_LF);
    add_byte(8'hFF);
    add_byte(CH_CR);
    add_byte(8'h00);
    add_byte(CH_COLON);
    add_byte(CH_CR);
    add_byte(8'h7F);
    add_byte(CH_LF);
    add_text(":v");
    add_byte(CH_LF);
    add_byte(CH_CR);
    add_byte(CH_LF, 1'b1);
    add_text("z");
    // line without colon
    fresh = 1'b1;
    add_text("no");
    add_byte(CH_LF);
    // held CR, then a byte ending the chunk: three words from one byte
    fresh = 1'b1;
    add_byte(CH_CR);
    add_byte(8'h71, 1'b1);
    fresh = 1'b1;
    add_byte(CH_LF, 1'b1);
    steady = 1'b0;
    send_msg();
    settle();

    // tight limits: name and value overruns, CR dropped on error
    write_reg(CFG_NAME_LIMIT, CFG_W'(2));
    write_reg(CFG_VALUE_LIMIT, CFG_W'(3));
    fresh = 1'b1;
    add_text("a");
    add_byte(CH_CR);
    add_text("x");
    fresh = 1'b1;
    add_text(": vwx");
    send_msg();
    settle();

    run_phase(1, 1);
    run_phase(1024, 65535);
    run_phase(5, 7);
    run_phase(256, 8192);
    run_phase(3, 40);
    run_phase($urandom_range(1, 12), $urandom_range(1, 24));

    settle();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && tokens_owed == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
